// File: design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: design/tlpeq_pkg.sv
// types and constants of the three-level priority event queue
package tlpeq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_LEVELS  = 3;
  localparam int EVENT_W     = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LVL_W       = 2;
  localparam int ADDR_W      = $clog2(NUM_LEVELS * QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADLVL = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] event_data;
    logic [1:0]  level;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_event;
    logic [1:0]  out_level;
    logic [1:0]  status;
    logic [4:0]  high_count;
    logic [4:0]  medium_count;
    logic [4:0]  low_count;
  } result_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage

// File: design/tlpeq_ctrl.sv
// controller state machine of the priority event queue
module tlpeq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  output tlpeq_pkg::ctrl_t ctrl
);
  import tlpeq_pkg::*;

  state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    done       = 1'b0;
    ctrl.load  = 1'b0;
    ctrl.exec  = 1'b0;
    case (state)
      S_IDLE: begin
        ctrl.load = start;
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        busy       = 1'b1;
        ctrl.exec  = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        done      = 1'b1;
        ctrl.load = start;
        state_next = start ? S_EXEC : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/tlpeq_datapath.sv
// queue store, pointers, counts and result registers
module tlpeq_datapath (
  input  logic               clk,
  input  logic               rst,
  input  tlpeq_pkg::ctrl_t   ctrl,
  input  tlpeq_pkg::in_item_t item,
  output tlpeq_pkg::result_t result
);
  import tlpeq_pkg::*;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  logic [1:0]         cmd_q;
  logic [EVENT_W-1:0] data_q;
  logic [LVL_W-1:0]   lvl_q;

  logic [PTR_W-1:0] head [NUM_LEVELS];
  logic [PTR_W-1:0] tail [NUM_LEVELS];
  logic [CNT_W-1:0] cnt  [NUM_LEVELS];

  logic [EVENT_W-1:0] mem [NUM_LEVELS * QUEUE_DEPTH];
  logic [EVENT_W-1:0] rd_data;

  logic             add_ok;
  logic             pop_found;
  logic [LVL_W-1:0] sel_lvl;
  logic [1:0]       status_c;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  logic             res_pop;
  logic [LVL_W-1:0] res_level;
  logic [1:0]       res_status;

  // command capture on transfer
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q  <= item.cmd;
      data_q <= item.event_data;
      lvl_q  <= item.level;
    end
  end

  always_comb begin
    add_ok = 1'b0;
    if (lvl_q < LVL_W'(NUM_LEVELS)) begin
      add_ok = cnt[lvl_q] < CNT_W'(QUEUE_DEPTH);
    end
  end

  // lowest-numbered non-empty level (level 0, the high level) wins
  always_comb begin
    pop_found = 1'b0;
    sel_lvl   = '0;
    for (int q = NUM_LEVELS - 1; q >= 0; q--) begin
      if (cnt[q] != '0) begin
        pop_found = 1'b1;
        sel_lvl   = LVL_W'(q);
      end
    end
  end

  always_comb begin
    status_c = ST_OK;
    case (cmd_q)
      CMD_ADD: begin
        if (lvl_q >= LVL_W'(NUM_LEVELS)) status_c = ST_BADLVL;
        else if (!add_ok) status_c = ST_FULL;
      end
      CMD_POP: begin
        if (!pop_found) status_c = ST_EMPTY;
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
  end

  always_comb begin
    wr_addr = '0;
    if (lvl_q < LVL_W'(NUM_LEVELS)) begin
      wr_addr = ADDR_W'(lvl_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail[lvl_q]);
    end
    rd_addr = ADDR_W'(sel_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head[sel_lvl]);
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec && cmd_q == CMD_ADD && add_ok) begin
      mem[wr_addr] <= data_q;
    end
    if (ctrl.exec) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NUM_LEVELS; q++) begin
        head[q] <= '0;
        tail[q] <= '0;
        cnt[q]  <= '0;
      end
    end else if (ctrl.exec) begin
      case (cmd_q)
        CMD_ADD: begin
          if (add_ok) begin
            tail[lvl_q] <= advance(tail[lvl_q]);
            cnt[lvl_q]  <= cnt[lvl_q] + 1'b1;
          end
        end
        CMD_POP: begin
          if (pop_found) begin
            head[sel_lvl] <= advance(head[sel_lvl]);
            cnt[sel_lvl]  <= cnt[sel_lvl] - 1'b1;
          end
        end
        CMD_CLEAR: begin
          for (int q = 0; q < NUM_LEVELS; q++) begin
            head[q] <= '0;
            tail[q] <= '0;
            cnt[q]  <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      res_pop    <= (cmd_q == CMD_POP) && pop_found;
      res_level  <= ((cmd_q == CMD_POP) && pop_found) ? sel_lvl : '0;
      res_status <= status_c;
    end
  end

  always_comb begin
    result.out_event    = res_pop ? rd_data : '0;
    result.out_level    = res_level;
    result.status       = res_status;
    result.high_count   = 5'(cnt[0]);
    result.medium_count = 5'(cnt[1]);
    result.low_count    = 5'(cnt[2]);
  end

endmodule

// File: design/three_level_priority_event_queue.sv
// top level of the three-level strict-priority event queue
// usage:
//   a command is transferred at a rising edge where start is high and busy is low.
//   item carries cmd (add, pop, clear), event_data and level.
//   every command gives exactly one result on result, marked by done for one
//   cycle; the receiver takes it at the edge that ends that cycle.
//   the command is executed in the execute state; its result is registered
//   and shown in the result state that follows. a new command may be
//   transferred in the cycle where the previous result is shown; the
//   controller takes no command in its execute state, where busy is high.
//   pop returns the head of the lowest-numbered non-empty level, or status empty.
//   add to a full queue drops the event; add at level three is ignored.
//   every result carries the three queue counts after the command.
//   reset clears pointers and counts at once; the store needs no clearing.
//   results cannot be held off, so done is a single-cycle strobe.
`include "assert_macros.svh"

module three_level_priority_event_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tlpeq_pkg::in_item_t item,
  output logic                busy,
  output logic                done,
  output tlpeq_pkg::result_t  result
);
  import tlpeq_pkg::*;

  ctrl_t ctrl;
  logic  counts_in_range;
  logic  empty_result;

  tlpeq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl)
  );

  tlpeq_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .item   (item),
    .result (result)
  );

  assign counts_in_range = (result.high_count <= 5'(QUEUE_DEPTH)) &&
                           (result.medium_count <= 5'(QUEUE_DEPTH)) &&
                           (result.low_count <= 5'(QUEUE_DEPTH));
  assign empty_result    = (result.high_count == '0) && (result.medium_count == '0) &&
                           (result.low_count == '0) && (result.out_event == '0);

  `ASSERT_NEXT(a_transfer_busy, clk, rst, start && !busy, busy)
  `ASSERT_NEXT(a_busy_done, clk, rst, busy, done && !busy)
  `ASSERT_IMPLY(a_count_range, clk, rst, done, counts_in_range)
  `ASSERT_IMPLY(a_empty_counts, clk, rst, done && (result.status == ST_EMPTY), empty_result)

endmodule
